// ----- rtl/trle_pkg.sv -----
package trle_pkg;

	localparam int BPP_W      = 3;
	localparam int COUNT_W    = 32;
	localparam int PIXEL_W    = 32;
	localparam int REPEAT_W   = 8;
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = 1;
	localparam int QUEUE_CNT_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT     = 1'b1;

	localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd4;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 32'd1;

	// One finished pixel handed from the packet parser to the pixel counter.
	typedef struct packed {
		logic [PIXEL_W-1:0]  color;
		logic [REPEAT_W-1:0] wanted;
		logic                more;
		logic                new_image;
	} pixel_rec_t;

	// Sizes of zero act as one and sizes above four act as four.
	function automatic logic [BPP_W-1:0] clamp_bpp(input logic [BPP_W-1:0] raw);
		logic [BPP_W-1:0] r;
		begin
			r = raw;
			if (raw == 3'd0) begin
				r = 3'd1;
			end else if (raw > 3'd4) begin
				r = 3'd4;
			end
			return r;
		end
	endfunction

endpackage

// ----- rtl/trle_front.sv -----
module trle_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [trle_pkg::BYTE_W-1:0]   data_byte,
	input  logic                          image_start,
	input  logic [trle_pkg::BPP_W-1:0]    bytes_per_pixel,
	output logic                          push,
	output trle_pkg::pixel_rec_t          rec
);
	import trle_pkg::*;

	logic                awaiting_q;
	logic                run_q;
	logic [REPEAT_W-1:0] left_q;
	logic [1:0]          slot_q;
	logic [PIXEL_W-1:0]  color_q;
	logic                new_image_q;

	logic                is_header;
	logic [BPP_W-1:0]    bpp;
	logic                pixel_done;
	logic [PIXEL_W-1:0]  color_next;
	logic [REPEAT_W-1:0] left_after;

	always_comb begin
		is_header  = image_start | awaiting_q;
		bpp        = clamp_bpp(bytes_per_pixel);
		color_next = color_q | ({{(PIXEL_W-BYTE_W){1'b0}}, data_byte} << {slot_q, 3'b000});
		pixel_done = ({1'b0, slot_q} + 3'd1) >= bpp;
		left_after = run_q ? '0 : left_q - 8'd1;
		push       = accept & ~is_header & pixel_done;
		rec.color     = color_next;
		rec.wanted    = run_q ? left_q : 8'd1;
		rec.more      = left_after != '0;
		rec.new_image = new_image_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q  <= 1'b1;
			run_q       <= 1'b0;
			left_q      <= '0;
			slot_q      <= '0;
			new_image_q <= 1'b0;
		end else if (accept) begin
			if (is_header) begin
				awaiting_q <= 1'b0;
				run_q      <= data_byte[7];
				left_q     <= data_byte[7] ? data_byte - 8'd127 : data_byte + 8'd1;
				slot_q     <= '0;
				if (image_start) begin
					new_image_q <= 1'b1;
				end
			end else if (pixel_done) begin
				slot_q      <= '0;
				left_q      <= left_after;
				awaiting_q  <= left_after == '0;
				new_image_q <= 1'b0;
			end else begin
				slot_q <= slot_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (is_header || pixel_done) begin
				color_q <= '0;
			end else begin
				color_q <= color_next;
			end
		end
	end

endmodule

// ----- rtl/trle_queue.sv -----
module trle_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  trle_pkg::pixel_rec_t push_rec,
	input  logic                 pop,
	output trle_pkg::pixel_rec_t head,
	output logic                 empty,
	output logic                 full
);
	import trle_pkg::*;

	pixel_rec_t             mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_q;
	logic [QUEUE_PTR_W-1:0] rd_q;
	logic [QUEUE_CNT_W-1:0] cnt_q;

	assign empty = cnt_q == '0;
	assign full  = cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_rec;
		end
	end

endmodule

// ----- rtl/trle_back.sv -----
module trle_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  trle_pkg::pixel_rec_t          head,
	input  logic                          empty,
	input  logic [trle_pkg::COUNT_W-1:0]  pixel_count,
	output logic                          pop,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [trle_pkg::PIXEL_W-1:0]  pixel_value,
	output logic [trle_pkg::REPEAT_W-1:0] repeat_count,
	output logic                          image_end,
	output logic                          overrun
);
	import trle_pkg::*;

	logic [COUNT_W-1:0]  done_q;
	logic                complete_q;
	logic                valid_q;
	logic [PIXEL_W-1:0]  value_q;
	logic [REPEAT_W-1:0] count_q;
	logic                end_q;
	logic                over_q;

	logic [COUNT_W-1:0]  done_eff;
	logic                complete_eff;
	logic [COUNT_W-1:0]  total;
	logic [COUNT_W-1:0]  room;
	logic                at_end;
	logic                over;
	logic [REPEAT_W-1:0] n;
	logic                drop;

	always_comb begin
		done_eff     = head.new_image ? '0 : done_q;
		complete_eff = head.new_image ? 1'b0 : complete_q;
		total        = (pixel_count == '0) ? COUNT_RESET : pixel_count;
		room         = (done_eff < total) ? total - done_eff : COUNT_W'(1);
		at_end       = {{(COUNT_W-REPEAT_W){1'b0}}, head.wanted} >= room;
		n            = at_end ? room[REPEAT_W-1:0] : head.wanted;
		over         = ({{(COUNT_W-REPEAT_W){1'b0}}, head.wanted} > room) | (at_end & head.more);
		pop          = ~empty & (~valid_q | out_ready);
		drop         = complete_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q     <= '0;
			complete_q <= 1'b0;
			valid_q    <= 1'b0;
		end else begin
			if (pop) begin
				if (drop) begin
					done_q     <= done_eff;
					complete_q <= complete_eff;
				end else begin
					done_q     <= done_eff + {{(COUNT_W-REPEAT_W){1'b0}}, n};
					complete_q <= at_end;
				end
			end
			if (pop && !drop) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !drop) begin
			value_q <= head.color;
			count_q <= n;
			end_q   <= at_end;
			over_q  <= over;
		end
	end

	assign out_valid    = valid_q;
	assign pixel_value  = value_q;
	assign repeat_count = count_q;
	assign image_end    = end_q;
	assign overrun      = over_q;

endmodule

// ----- rtl/tga_rle_packet_decoder.sv -----
// Decodes run-length coded TGA pixel data, one byte a cycle on the input, and gives one
// pixel with its repeat count per request on the output, at up to one result a cycle. A
// packet parser builds pixels from the bytes and hands them through a two-entry queue to a
// pixel counter, which clips packets at the configured pixel count and sets tlast on the
// result that completes the image; later bytes are dropped until tuser marks a new image.
// The input stalls only when the queue is full because the output is held. Configuration
// writes are always taken and must only be made while the block is idle.
module tga_rle_packet_decoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,  // data_byte [7:0]
	input  logic                            s_tuser,  // image_start
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [39:0]                     m_tdata,  // pixel_value [31:0], repeat_count [39:32]
	output logic                            m_tlast,
	output logic                            m_tuser,  // overrun
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [trle_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [trle_pkg::CFG_DATA_W-1:0] cfg_data
);
	import trle_pkg::*;

	logic [BPP_W-1:0]    bpp_q;
	logic [COUNT_W-1:0]  pixel_count_q;
	logic                accept;
	logic                push;
	logic                pop;
	logic                empty;
	logic                full;
	pixel_rec_t          push_rec;
	pixel_rec_t          head;
	logic [PIXEL_W-1:0]  pixel_value;
	logic [REPEAT_W-1:0] repeat_count;

	assign cfg_ready = 1'b1;
	assign s_tready  = ~full;
	assign accept    = s_tvalid & s_tready;
	assign m_tdata   = {repeat_count, pixel_value};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q         <= BPP_RESET;
			pixel_count_q <= COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BYTES_PER_PIXEL: bpp_q         <= cfg_data[BPP_W-1:0];
				REG_PIXEL_COUNT:     pixel_count_q <= cfg_data[COUNT_W-1:0];
				default:             ;
			endcase
		end
	end

	trle_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.data_byte       (s_tdata),
		.image_start     (s_tuser),
		.bytes_per_pixel (bpp_q),
		.push            (push),
		.rec             (push_rec)
	);

	trle_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	trle_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pixel_count  (pixel_count_q),
		.pop          (pop),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.pixel_value  (pixel_value),
		.repeat_count (repeat_count),
		.image_end    (m_tlast),
		.overrun      (m_tuser)
	);

	a_overrun_ends_image: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("overrun flagged on a result that does not end the image");

	a_repeat_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[39:32] != 8'd0) && (m_tdata[39:32] <= 8'd128))
		else $error("repeat count out of range");

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled while no result is held");

endmodule
